>>> rtl/qcls_pkg.sv
package qcls_pkg;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LOWN   = 8'h6E;
  localparam logic [7:0] CH_LOWT   = 8'h74;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNBALANCED = 2'd1;
  localparam logic [1:0] ERR_BSLASH_END = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_done;
    logic       string_done;
    logic [1:0] error_code;
  } out_word_t;

  typedef struct packed {
    logic escape_pending;
    logic in_quote;
    logic quote_is_single;
    logic token_nonempty;
  } split_state_t;

  localparam split_state_t STATE_RESET = '0;

endpackage

>>> rtl/qcls_in_if.sv
interface qcls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       end_of_string;

  modport source (output valid, ch, has_char, end_of_string, input ready);
  modport sink (input valid, ch, has_char, end_of_string, output ready);
endinterface

>>> rtl/qcls_out_if.sv
interface qcls_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       token_done;
  logic       string_done;
  logic [1:0] error_code;

  modport source (output valid, out_char, char_valid, token_done, string_done, error_code,
                  input ready);
  modport sink (input valid, out_char, char_valid, token_done, string_done, error_code,
                output ready);
endinterface

>>> rtl/qcls_step.sv
module qcls_step (
  input  qcls_pkg::in_word_t     word,
  input  qcls_pkg::split_state_t state,
  output qcls_pkg::split_state_t state_next,
  output qcls_pkg::out_word_t    result
);

  logic [7:0] ochar;
  logic       valid;
  logic       tdone;
  logic       is_single;
  qcls_pkg::split_state_t st;

  always_comb begin
    st        = state;
    ochar     = '0;
    valid     = 1'b0;
    tdone     = 1'b0;
    is_single = (word.ch == qcls_pkg::CH_SQUOTE);
    result    = '0;

    if (word.has_char) begin
      if (st.escape_pending) begin
        case (word.ch)
          qcls_pkg::CH_LOWN: ochar = qcls_pkg::CH_NL;
          qcls_pkg::CH_LOWT: ochar = qcls_pkg::CH_TAB;
          default:           ochar = word.ch;
        endcase
        valid = 1'b1;
        st.escape_pending = 1'b0;
      end else if (word.ch == qcls_pkg::CH_BSLASH) begin
        st.escape_pending = 1'b1;
      end else if (word.ch == qcls_pkg::CH_SPACE) begin
        if (st.in_quote) begin
          ochar = word.ch;
          valid = 1'b1;
        end else begin
          tdone = st.token_nonempty;
          st.token_nonempty = 1'b0;
        end
      end else if (word.ch == qcls_pkg::CH_DQUOTE || is_single) begin
        if (!st.in_quote) begin
          st.in_quote        = 1'b1;
          st.quote_is_single = is_single;
        end else if (st.quote_is_single == is_single) begin
          st.in_quote = 1'b0;
        end else begin
          ochar = word.ch;
          valid = 1'b1;
        end
      end else begin
        ochar = word.ch;
        valid = 1'b1;
      end
      if (valid) begin
        st.token_nonempty = 1'b1;
      end
    end

    if (word.end_of_string) begin
      result.string_done = 1'b1;
      if (st.escape_pending) begin
        result.error_code = qcls_pkg::ERR_BSLASH_END;
      end else if (st.in_quote) begin
        result.error_code = qcls_pkg::ERR_UNBALANCED;
      end else if (st.token_nonempty) begin
        tdone = 1'b1;
      end
      st = qcls_pkg::STATE_RESET;
    end

    result.out_char   = ochar;
    result.char_valid = valid;
    result.token_done = tdone;
    state_next        = st;
  end

endmodule

>>> rtl/quoted_command_line_splitter.sv
// Shell-style command line splitter.
// cmd carries one byte of the command line per word (ch, has_char) and
// end_of_string on the word after which the line ends. tok returns exactly
// one word per cmd word: the token byte appended (out_char, char_valid),
// token_done where a non-empty token closes, and string_done with
// error_code on the word that ends the line.
// A word passes through an input register, then a result register, on its
// way to tok. Throughput: one word per cycle while tok is ready; the
// quote/escape flags are updated as a word moves from the input register
// into the result register.
// Reset (rst, synchronous) empties both registers and clears the quote,
// escape and token flags; cmd.ready is high once the input register is emptied.
// When tok stalls the result register holds, the input register fills
// behind it and cmd.ready drops; no word is lost or repeated.
module quoted_command_line_splitter (
  input  logic              clk,
  input  logic              rst,
  qcls_in_if.sink           cmd,
  qcls_out_if.source        tok
);

  qcls_pkg::in_word_t     in_word;
  logic                   in_valid;
  qcls_pkg::split_state_t state;
  qcls_pkg::split_state_t state_next;
  qcls_pkg::out_word_t    step_result;
  qcls_pkg::out_word_t    out_word;
  logic                   out_valid;
  logic                   advance;

  assign advance   = in_valid && (!out_valid || tok.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
    if (cmd.ready && cmd.valid) begin
      in_word.ch            <= cmd.ch;
      in_word.has_char      <= cmd.has_char;
      in_word.end_of_string <= cmd.end_of_string;
    end
  end

  qcls_step u_step (
    .word       (in_word),
    .state      (state),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qcls_pkg::STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (tok.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_word <= step_result;
    end
  end

  assign tok.valid       = out_valid;
  assign tok.out_char    = out_word.out_char;
  assign tok.char_valid  = out_word.char_valid;
  assign tok.token_done  = out_word.token_done;
  assign tok.string_done = out_word.string_done;
  assign tok.error_code  = out_word.error_code;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qcls_in_if  cmd_if ();
  qcls_out_if tok_if ();

  quoted_command_line_splitter DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .tok (tok_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  qcls_pkg::split_state_t split_flags = qcls_pkg::STATE_RESET;
  qcls_pkg::out_word_t    expected_words[$];
  qcls_pkg::in_word_t     line_words[$];

  bit quiet_phase = 1'b0;
  int stall_left  = 0;
  int fails       = 0;
  int words_sent  = 0;
  int random_sent = 0;
  int tokens_seen = 0;
  int lines_seen  = 0;
  int quote_errs  = 0;
  int bslash_errs = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic qcls_pkg::out_word_t predict_word(input qcls_pkg::in_word_t w);
    qcls_pkg::out_word_t r;
    r = '0;
    if (w.has_char) begin
      if (split_flags.escape_pending) begin
        r.out_char = (w.ch == qcls_pkg::CH_LOWN) ? qcls_pkg::CH_NL :
                     (w.ch == qcls_pkg::CH_LOWT) ? qcls_pkg::CH_TAB : w.ch;
        r.char_valid = 1'b1;
        split_flags.escape_pending = 1'b0;
      end else if (w.ch == qcls_pkg::CH_BSLASH) begin
        split_flags.escape_pending = 1'b1;
      end else if (w.ch == qcls_pkg::CH_SPACE) begin
        if (split_flags.in_quote) begin
          r.out_char   = w.ch;
          r.char_valid = 1'b1;
        end else begin
          r.token_done = split_flags.token_nonempty;
          split_flags.token_nonempty = 1'b0;
        end
      end else if (w.ch == qcls_pkg::CH_DQUOTE || w.ch == qcls_pkg::CH_SQUOTE) begin
        if (!split_flags.in_quote) begin
          split_flags.in_quote        = 1'b1;
          split_flags.quote_is_single = (w.ch == qcls_pkg::CH_SQUOTE);
        end else if (split_flags.quote_is_single == (w.ch == qcls_pkg::CH_SQUOTE)) begin
          split_flags.in_quote = 1'b0;
        end else begin
          r.out_char   = w.ch;
          r.char_valid = 1'b1;
        end
      end else begin
        r.out_char   = w.ch;
        r.char_valid = 1'b1;
      end
      if (r.char_valid) split_flags.token_nonempty = 1'b1;
    end
    if (w.end_of_string) begin
      r.string_done = 1'b1;
      if (split_flags.escape_pending) begin
        r.error_code = qcls_pkg::ERR_BSLASH_END;
      end else if (split_flags.in_quote) begin
        r.error_code = qcls_pkg::ERR_UNBALANCED;
      end else if (split_flags.token_nonempty) begin
        r.token_done = 1'b1;
      end
      split_flags = qcls_pkg::STATE_RESET;
    end
    return r;
  endfunction

  task automatic send_word(input qcls_pkg::in_word_t w);
    int idle;
    qcls_pkg::out_word_t res;
    idle = quiet_phase ? 0 : pick_gap();
    if (idle > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.ch            <= w.ch;
    cmd_if.has_char      <= w.has_char;
    cmd_if.end_of_string <= w.end_of_string;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    res = predict_word(w);
    expected_words = {expected_words, res};
    words_sent++;
    if (res.token_done) tokens_seen++;
    if (res.string_done) lines_seen++;
    if (res.error_code == qcls_pkg::ERR_UNBALANCED) quote_errs++;
    if (res.error_code == qcls_pkg::ERR_BSLASH_END) bslash_errs++;
  endtask

  task automatic send_text(input string s, input bit end_last);
    qcls_pkg::in_word_t w;
    for (int i = 0; i < s.len(); i++) begin
      w = '{ch: s[i], has_char: 1'b1, end_of_string: end_last && (i == s.len() - 1)};
      send_word(w);
    end
  endtask

  task automatic check_result();
    qcls_pkg::out_word_t act;
    qcls_pkg::out_word_t exp;
    act = '{out_char: tok_if.out_char, char_valid: tok_if.char_valid,
            token_done: tok_if.token_done, string_done: tok_if.string_done,
            error_code: tok_if.error_code};
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word char=%h valid=%b tdone=%b sdone=%b err=%0d",
               $time, act.out_char, act.char_valid, act.token_done, act.string_done,
               act.error_code);
      fails++;
    end else begin
      exp = expected_words.pop_front();
      if (exp !== act) begin
        $display("%0t: mismatch expected char=%h valid=%b tdone=%b sdone=%b err=%0d",
                 $time, exp.out_char, exp.char_valid, exp.token_done, exp.string_done,
                 exp.error_code);
        $display("%0t:          actual   char=%h valid=%b tdone=%b sdone=%b err=%0d",
                 $time, act.out_char, act.char_valid, act.token_done, act.string_done,
                 act.error_code);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (quiet_phase) begin
      tok_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      tok_if.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      tok_if.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
    if (!rst && tok_if.valid && tok_if.ready) check_result();
  end

  function automatic logic [7:0] plain_byte();
    if ($urandom_range(0, 9) < 6) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] escaped_byte();
    case ($urandom_range(0, 5))
      0: return qcls_pkg::CH_LOWN;
      1: return qcls_pkg::CH_LOWT;
      2: return qcls_pkg::CH_SPACE;
      3: return ($urandom_range(0, 1) != 0) ? qcls_pkg::CH_SQUOTE : qcls_pkg::CH_DQUOTE;
      4: return qcls_pkg::CH_BSLASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    qcls_pkg::in_word_t w;
    w = '{ch: b, has_char: 1'b1, end_of_string: 1'b0};
    line_words = {line_words, w};
  endtask

  task automatic build_line();
    logic [7:0] q;
    logic [7:0] b;
    int nseg;
    int k;
    qcls_pkg::in_word_t tail;
    line_words.delete();
    nseg = $urandom_range(1, 6);
    for (int s = 0; s < nseg; s++) begin
      k = $urandom_range(0, 9);
      if (k < 4) begin
        repeat ($urandom_range(1, 5)) add_byte(plain_byte());
      end else if (k < 6) begin
        q = ($urandom_range(0, 1) != 0) ? qcls_pkg::CH_SQUOTE : qcls_pkg::CH_DQUOTE;
        add_byte(q);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 5))
            0: add_byte(qcls_pkg::CH_SPACE);
            1: add_byte((q == qcls_pkg::CH_SQUOTE) ? qcls_pkg::CH_DQUOTE : qcls_pkg::CH_SQUOTE);
            2: begin
              add_byte(qcls_pkg::CH_BSLASH);
              add_byte(escaped_byte());
            end
            default: begin
              b = plain_byte();
              add_byte((b == q || b == qcls_pkg::CH_BSLASH) ? qcls_pkg::CH_SPACE : b);
            end
          endcase
        end
        add_byte(q);
      end else if (k == 6) begin
        add_byte(qcls_pkg::CH_BSLASH);
        add_byte(escaped_byte());
      end else begin
        repeat ($urandom_range(1, 3)) add_byte(qcls_pkg::CH_SPACE);
      end
    end
    k = $urandom_range(0, 19);
    if (k < 2) begin
      add_byte(qcls_pkg::CH_BSLASH);
    end else if (k < 4) begin
      add_byte(($urandom_range(0, 1) != 0) ? qcls_pkg::CH_SQUOTE : qcls_pkg::CH_DQUOTE);
      if (k == 3) add_byte(plain_byte());
    end
    if ($urandom_range(0, 1) != 0) begin
      line_words[line_words.size() - 1].end_of_string = 1'b1;
    end else begin
      tail = '{ch: 8'($urandom_range(0, 255)), has_char: 1'b0, end_of_string: 1'b1};
      line_words = {line_words, tail};
    end
  endtask

  task automatic send_line();
    foreach (line_words[i]) begin
      if ($urandom_range(0, 24) == 0) begin
        send_word('{ch: 8'($urandom_range(0, 255)), has_char: 1'b0, end_of_string: 1'b0});
      end
      send_word(line_words[i]);
      random_sent++;
    end
  endtask

  task automatic test_extreme_bytes();
    send_word('{ch: 8'h00, has_char: 1'b1, end_of_string: 1'b0});
    send_word('{ch: 8'hFF, has_char: 1'b1, end_of_string: 1'b1});
  endtask

  task automatic test_spaces_and_bare();
    send_word('{ch: 8'hA5, has_char: 1'b0, end_of_string: 1'b0});
    send_text("a b", 1'b0);
    send_word('{ch: 8'h5A, has_char: 1'b0, end_of_string: 1'b1});
  endtask

  task automatic test_quoting();
    send_text("\"' \"", 1'b1);
    send_text("''", 1'b1);
  endtask

  task automatic test_escapes();
    send_text("\\n\\t", 1'b1);
  endtask

  task automatic test_unterminated();
    send_text("'a", 1'b1);
    send_text("\"\\", 1'b1);
  endtask

  task automatic test_random_lines(input int target);
    while (random_sent < target) begin
      if ($urandom_range(0, 14) == 0) quiet_phase = !quiet_phase;
      if ($urandom_range(0, 4) == 0) begin
        // noise: any byte, any flags
        repeat ($urandom_range(1, 8)) begin
          send_word('{ch: 8'($urandom_range(0, 255)), has_char: 1'($urandom_range(0, 1)),
                      end_of_string: ($urandom_range(0, 7) == 0)});
          random_sent++;
        end
      end else begin
        build_line();
        send_line();
      end
    end
    quiet_phase = 1'b0;
  endtask

  initial begin
    cmd_if.valid         = 1'b0;
    cmd_if.ch            = 8'h00;
    cmd_if.has_char      = 1'b0;
    cmd_if.end_of_string = 1'b0;
    tok_if.ready         = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_extreme_bytes();
    test_spaces_and_bare();
    test_quoting();
    test_escapes();
    test_unterminated();
    test_random_lines(530);

    cmd_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d words: %0d tokens closed over %0d lines", words_sent, tokens_seen,
             lines_seen);
    $display("Error endings: %0d open quote, %0d trailing backslash", quote_errs, bslash_errs);
    if (fails == 0) begin
      $display("quoted_command_line_splitter regression: pass");
    end else begin
      $display("quoted_command_line_splitter regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timed out", $time);
    $display("quoted_command_line_splitter regression: fail");
    $finish;
  end

endmodule
